// ===== hw/rtl/isu_pkg.sv =====
// isu_pkg: shared widths, codes and types for the Ising spin update block
// no dependencies; imported by every module of the block but isu_row_ram
`default_nettype none

package isu_pkg;

    // fixed payload widths
    localparam int SITE_W   = 12;
    localparam int RND_W    = 16;
    localparam int PROB_W   = 16;
    localparam int ENERGY_W = 15;
    localparam int MAG_W    = 14;
    localparam int DE_W     = 5;

    // default lattice edge length
    localparam int DEF_LATTICE_SIDE = 64;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_DE4 = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_DE8 = 1'b1;

    // request operation codes
    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // energy change of one flip, -8 .. 8
    typedef logic signed [DE_W-1:0] de_t;

    // outcome of one request at the selected site
    typedef struct packed {
        logic do_flip;
        logic spin_new;
        de_t  de;
    } flip_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ising_metropolis_spin_update.sv =====
// ising_metropolis_spin_update: 2D Ising lattice with Metropolis single-spin updates
// depends on isu_pkg, isu_row_ram, isu_site_decode, isu_flip_eval
//
// Usage: requests enter on the s_ channel (op, site, spin_value, random_fraction)
// and each produces exactly one result on the m_ channel (flipped, spin_now,
// energy, magnetization). Both channels use valid/ready. The two acceptance
// thresholds are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while the block is idle, the block does not enforce this. Throughput:
// one request per cycle while the m_ channel keeps taking results. A request passes
// the estimate stage, the row read stage and the result register in that order.
// The lattice is held as rows in three copies of a row memory so that the north,
// center and south rows are read in the same cycle; a one-row bypass covers the row
// written at the same edge as the next read.
// Reset: the totals and thresholds return to their reset values, then a clearing
// pass writes every row to all spins up, with s_ready low.
// Stalls: each stage moves when the one after it is free, so requests keep being
// accepted while a result waits, until all three stages are full.
`default_nettype none

module ising_metropolis_spin_update
    import isu_pkg::*;
#(
    parameter int LATTICE_SIDE = DEF_LATTICE_SIDE
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [PROB_W-1:0]          cfg_wdata,
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic                       s_op,
    input  wire logic [SITE_W-1:0]          s_site,
    input  wire logic                       s_spin_value,
    input  wire logic [RND_W-1:0]           s_random_fraction,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic                       m_flipped,
    output      logic                       m_spin_now,
    output      logic signed [ENERGY_W-1:0] m_energy,
    output      logic signed [MAG_W-1:0]    m_magnetization
);

    localparam int CW         = $clog2(LATTICE_SIDE);
    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int DIV_SHIFT  = 24;
    localparam int RECIP      = (1 << DIV_SHIFT) / LATTICE_SIDE;
    localparam int PROD_W     = SITE_W + DIV_SHIFT;
    localparam logic [CW-1:0] SIDE_M1 = CW'(LATTICE_SIDE - 1);
    localparam logic signed [ENERGY_W-1:0] ENERGY_INIT = ENERGY_W'(-2 * SITE_COUNT);
    localparam logic signed [MAG_W-1:0]    MAG_INIT    = MAG_W'(SITE_COUNT);
    localparam logic signed [MAG_W-1:0]    MAG_STEP    = MAG_W'(2);

    // configuration
    logic [PROB_W-1:0] accept_de4_reg;
    logic [PROB_W-1:0] accept_de8_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [CW-1:0] clr_cnt_reg;

    // handshake
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic s1_load;
    logic s2_load;
    logic out_load;

    // stage 1: request and quotient estimate
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [SITE_W-1:0] s1_site_reg;
    logic              s1_spin_reg;
    logic [RND_W-1:0]  s1_rnd_reg;
    logic [SITE_W-1:0] s1_quot_reg;
    logic              s1_in_range_reg;
    logic [PROD_W-1:0] recip_prod;

    // stage 1 decode outputs
    logic [CW-1:0] dec_x;
    logic [CW-1:0] dec_xe;
    logic [CW-1:0] dec_xw;
    logic [CW-1:0] dec_y;
    logic [CW-1:0] dec_yn;
    logic [CW-1:0] dec_ys;

    // stage 2: coordinates, rows held in the row memories
    logic             s2_valid_reg;
    logic             s2_op_reg;
    logic             s2_spin_reg;
    logic [RND_W-1:0] s2_rnd_reg;
    logic             s2_in_range_reg;
    logic [CW-1:0]    s2_x_reg;
    logic [CW-1:0]    s2_xe_reg;
    logic [CW-1:0]    s2_xw_reg;
    logic [CW-1:0]    s2_y_reg;
    logic [CW-1:0]    s2_yn_reg;
    logic [CW-1:0]    s2_ys_reg;

    // row memories and bypass of the last written row
    logic                    ram_we;
    logic [CW-1:0]           ram_waddr;
    logic [LATTICE_SIDE-1:0] ram_wdata;
    logic [LATTICE_SIDE-1:0] ram_north;
    logic [LATTICE_SIDE-1:0] ram_mid;
    logic [LATTICE_SIDE-1:0] ram_south;
    logic                    byp_valid_reg;
    logic [CW-1:0]           byp_row_reg;
    logic [LATTICE_SIDE-1:0] byp_data_reg;
    logic [LATTICE_SIDE-1:0] row_north;
    logic [LATTICE_SIDE-1:0] row_mid;
    logic [LATTICE_SIDE-1:0] row_south;
    logic [LATTICE_SIDE-1:0] row_new;
    logic                    upd_we;

    // evaluation and totals
    flip_result_t                fr;
    logic signed [ENERGY_W-1:0]  energy_reg;
    logic signed [ENERGY_W-1:0]  energy_next;
    logic signed [MAG_W-1:0]     mag_reg;
    logic signed [MAG_W-1:0]     mag_next;

    // result register
    logic                       m_valid_reg;
    logic                       m_flipped_reg;
    logic                       m_spin_now_reg;
    logic signed [ENERGY_W-1:0] m_energy_reg;
    logic signed [MAG_W-1:0]    m_mag_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_de4_reg <= '0;
            accept_de8_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ACCEPT_DE4: accept_de4_reg <= cfg_wdata;
                CFG_ACCEPT_DE8: accept_de8_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clearing pass after reset, one row per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SIDE_M1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // stage flow control
    always_comb begin
        out_ready = !m_valid_reg || m_ready;
        s2_ready  = !s2_valid_reg || out_ready;
        s1_ready  = !s1_valid_reg || s2_ready;
        s_ready   = s1_ready && !clr_active_reg;
        s1_load   = s_valid && s_ready;
        s2_load   = s1_valid_reg && s2_ready;
        out_load  = s2_valid_reg && out_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_load || (s1_valid_reg && !s2_ready);
            s2_valid_reg <= s2_load || (s2_valid_reg && !out_ready);
            m_valid_reg  <= out_load || (m_valid_reg && !m_ready);
        end
    end

    // row estimate by reciprocal multiply, low by at most one
    assign recip_prod = PROD_W'(s_site) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_op_reg       <= s_op;
            s1_site_reg     <= s_site;
            s1_spin_reg     <= s_spin_value;
            s1_rnd_reg      <= s_random_fraction;
            s1_quot_reg     <= recip_prod[PROD_W-1:DIV_SHIFT];
            s1_in_range_reg <= ({{(32 - SITE_W){1'b0}}, s_site} < 32'(SITE_COUNT));
        end
    end

    isu_site_decode #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_decode (
        .site     (s1_site_reg),
        .quot_est (s1_quot_reg),
        .in_range (s1_in_range_reg),
        .x        (dec_x),
        .x_east   (dec_xe),
        .x_west   (dec_xw),
        .y        (dec_y),
        .y_north  (dec_yn),
        .y_south  (dec_ys)
    );

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_op_reg       <= s1_op_reg;
            s2_spin_reg     <= s1_spin_reg;
            s2_rnd_reg      <= s1_rnd_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_x_reg        <= dec_x;
            s2_xe_reg       <= dec_xe;
            s2_xw_reg       <= dec_xw;
            s2_y_reg        <= dec_y;
            s2_yn_reg       <= dec_yn;
            s2_ys_reg       <= dec_ys;
        end
    end

    // row memory write: clearing pass or accepted flip
    always_comb begin
        upd_we = out_load && fr.do_flip;
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '1;
        end else begin
            ram_we    = upd_we;
            ram_waddr = s2_y_reg;
            ram_wdata = row_new;
        end
    end

    isu_row_ram #(
        .DEPTH (LATTICE_SIDE),
        .WIDTH (LATTICE_SIDE)
    ) u_ram_north (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s2_load),
        .raddr (dec_yn),
        .rdata (ram_north)
    );

    isu_row_ram #(
        .DEPTH (LATTICE_SIDE),
        .WIDTH (LATTICE_SIDE)
    ) u_ram_mid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s2_load),
        .raddr (dec_y),
        .rdata (ram_mid)
    );

    isu_row_ram #(
        .DEPTH (LATTICE_SIDE),
        .WIDTH (LATTICE_SIDE)
    ) u_ram_south (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s2_load),
        .raddr (dec_ys),
        .rdata (ram_south)
    );

    // bypass of the row written at the edge of the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (upd_we) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_we) begin
            byp_row_reg  <= s2_y_reg;
            byp_data_reg <= row_new;
        end
    end

    always_comb begin
        row_north = (byp_valid_reg && byp_row_reg == s2_yn_reg) ? byp_data_reg : ram_north;
        row_mid   = (byp_valid_reg && byp_row_reg == s2_y_reg)  ? byp_data_reg : ram_mid;
        row_south = (byp_valid_reg && byp_row_reg == s2_ys_reg) ? byp_data_reg : ram_south;
    end

    isu_flip_eval #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_eval (
        .op              (s2_op_reg),
        .spin_value      (s2_spin_reg),
        .random_fraction (s2_rnd_reg),
        .accept_de4      (accept_de4_reg),
        .accept_de8      (accept_de8_reg),
        .in_range        (s2_in_range_reg),
        .x               (s2_x_reg),
        .x_east          (s2_xe_reg),
        .x_west          (s2_xw_reg),
        .row_north       (row_north),
        .row_mid         (row_mid),
        .row_south       (row_south),
        .result          (fr),
        .row_new         (row_new)
    );

    // running totals
    always_comb begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        if (upd_we) begin
            energy_next = energy_reg + ENERGY_W'(fr.de);
            mag_next    = fr.spin_new ? (mag_reg + MAG_STEP) : (mag_reg - MAG_STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= ENERGY_INIT;
            mag_reg    <= MAG_INIT;
        end else begin
            energy_reg <= energy_next;
            mag_reg    <= mag_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_flipped_reg  <= fr.do_flip;
            m_spin_now_reg <= fr.spin_new;
            m_energy_reg   <= energy_next;
            m_mag_reg      <= mag_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_flipped       = m_flipped_reg;
    assign m_spin_now      = m_spin_now_reg;
    assign m_energy        = m_energy_reg;
    assign m_magnetization = m_mag_reg;

`ifndef SYNTHESIS
    // no request taken while rows are being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("request accepted during clearing pass");

    // bypass only ever holds a row written after the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        byp_valid_reg |-> !clr_active_reg)
        else $error("bypass valid during clearing pass");

    // a change of magnetization always comes with a valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(mag_reg) |-> m_valid_reg)
        else $error("magnetization changed without a result");

    // energy only moves together with magnetization
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(energy_reg) |-> !$stable(mag_reg))
        else $error("energy changed without a spin flip");

    // one flip moves magnetization by exactly two
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(mag_reg) |->
            (MAG_W'(mag_reg - $past(mag_reg)) == MAG_STEP) ||
            (MAG_W'($past(mag_reg) - mag_reg) == MAG_STEP))
        else $error("magnetization step is not two");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/isu_row_ram.sv =====
// isu_row_ram: one lattice row per entry, one write and one registered read port
// uses no package items
`default_nettype none

module isu_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isu_site_decode.sv =====
// isu_site_decode: splits a site index into column and row plus wrapped neighbours
// depends on isu_pkg; takes the reciprocal-estimated quotient from the top level
`default_nettype none

module isu_site_decode
    import isu_pkg::*;
#(
    parameter int LATTICE_SIDE = DEF_LATTICE_SIDE
) (
    input  wire logic [SITE_W-1:0]               site,
    input  wire logic [SITE_W-1:0]               quot_est,
    input  wire logic                            in_range,
    output      logic [$clog2(LATTICE_SIDE)-1:0] x,
    output      logic [$clog2(LATTICE_SIDE)-1:0] x_east,
    output      logic [$clog2(LATTICE_SIDE)-1:0] x_west,
    output      logic [$clog2(LATTICE_SIDE)-1:0] y,
    output      logic [$clog2(LATTICE_SIDE)-1:0] y_north,
    output      logic [$clog2(LATTICE_SIDE)-1:0] y_south
);

    localparam int CW = $clog2(LATTICE_SIDE);
    localparam int PW = 2 * SITE_W;
    localparam logic [SITE_W-1:0] SIDE_S = SITE_W'(LATTICE_SIDE);
    localparam logic [CW-1:0] SIDE_M1 = CW'(LATTICE_SIDE - 1);

    logic [PW-1:0]     base_prod;
    logic [SITE_W-1:0] rem;
    logic              corr;
    logic [SITE_W-1:0] x_full;
    logic [SITE_W-1:0] y_full;

    // remainder of the estimate, at most one correction step
    always_comb begin
        base_prod = PW'(quot_est) * PW'(LATTICE_SIDE);
        rem       = site - base_prod[SITE_W-1:0];
        corr      = (rem >= SIDE_S);
        x_full    = corr ? (rem - SIDE_S) : rem;
        y_full    = corr ? (quot_est + 1'b1) : quot_est;
    end

    // out-of-range sites park on row zero so the row address stays legal
    always_comb begin
        x = in_range ? x_full[CW-1:0] : '0;
        y = in_range ? y_full[CW-1:0] : '0;
    end

    // periodic neighbours
    always_comb begin
        x_east  = (x == SIDE_M1) ? '0 : x + 1'b1;
        x_west  = (x == '0) ? SIDE_M1 : x - 1'b1;
        y_south = (y == SIDE_M1) ? '0 : y + 1'b1;
        y_north = (y == '0) ? SIDE_M1 : y - 1'b1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isu_flip_eval.sv =====
// isu_flip_eval: Metropolis decision and new center row for one request
// depends on isu_pkg for widths, op codes and flip_result_t
`default_nettype none

module isu_flip_eval
    import isu_pkg::*;
#(
    parameter int LATTICE_SIDE = DEF_LATTICE_SIDE
) (
    input  wire logic                            op,
    input  wire logic                            spin_value,
    input  wire logic [RND_W-1:0]                random_fraction,
    input  wire logic [PROB_W-1:0]               accept_de4,
    input  wire logic [PROB_W-1:0]               accept_de8,
    input  wire logic                            in_range,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0] x,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0] x_east,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0] x_west,
    input  wire logic [LATTICE_SIDE-1:0]         row_north,
    input  wire logic [LATTICE_SIDE-1:0]         row_mid,
    input  wire logic [LATTICE_SIDE-1:0]         row_south,
    output      flip_result_t                    result,
    output      logic [LATTICE_SIDE-1:0]         row_new
);

    logic       spin_cur;
    logic [2:0] agree;
    logic       accept;
    logic       flip;
    logic       spin_next;
    de_t        de;

    // count neighbours aligned with the center spin
    always_comb begin
        spin_cur = row_mid[x];
        agree    = {2'b00, row_mid[x_east] ~^ spin_cur}
                 + {2'b00, row_mid[x_west] ~^ spin_cur}
                 + {2'b00, row_north[x] ~^ spin_cur}
                 + {2'b00, row_south[x] ~^ spin_cur};
    end

    // energy change and acceptance
    always_comb begin
        unique case (agree)
            3'd0:    begin de = de_t'(-8); accept = 1'b1; end
            3'd1:    begin de = de_t'(-4); accept = 1'b1; end
            3'd2:    begin de = de_t'(0);  accept = 1'b1; end
            3'd3:    begin de = de_t'(4);  accept = (random_fraction < accept_de4); end
            default: begin de = de_t'(8);  accept = (random_fraction < accept_de8); end
        endcase
    end

    // final decision and updated row
    always_comb begin
        if (op == OP_WRITE) begin
            flip = (spin_cur != spin_value);
        end else begin
            flip = accept;
        end
        flip      = flip & in_range;
        spin_next = in_range ? (spin_cur ^ flip) : 1'b0;
        row_new    = row_mid;
        row_new[x] = spin_next;
        result.do_flip  = flip;
        result.spin_new = spin_next;
        result.de       = de;
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for ising_metropolis_spin_update (default 64 x 64 lattice)
// depends on isu_pkg and the rtl; keeps its own copy of the lattice and totals
// and checks every result against it
`default_nettype none

module testbench;
    import isu_pkg::*;

    localparam int SIDE       = DEF_LATTICE_SIDE;
    localparam int SITE_COUNT = SIDE * SIDE;
    localparam int HOLD_OFF   = 200;
    localparam int END_WAIT   = 8;

    // expected outcome of one request
    typedef struct packed {
        logic                       flipped;
        logic                       spin_now;
        logic signed [ENERGY_W-1:0] energy;
        logic signed [MAG_W-1:0]    magnetization;
    } spin_outcome_t;

    // clock, reset and block ports
    logic                       aclk              = 1'b0;
    logic                       aresetn           = 1'b0;
    logic                       cfg_we            = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr          = CFG_ACCEPT_DE4;
    logic [PROB_W-1:0]          cfg_wdata         = '0;
    logic                       s_valid           = 1'b0;
    logic                       s_ready;
    logic                       s_op              = OP_FLIP;
    logic [SITE_W-1:0]          s_site            = '0;
    logic                       s_spin_value      = 1'b0;
    logic [RND_W-1:0]           s_random_fraction = '0;
    logic                       m_valid;
    logic                       m_ready           = 1'b0;
    logic                       m_flipped;
    logic                       m_spin_now;
    logic signed [ENERGY_W-1:0] m_energy;
    logic signed [MAG_W-1:0]    m_magnetization;

    // predicted lattice state and thresholds
    logic                       lattice_spin [0:SITE_COUNT-1];
    logic signed [ENERGY_W-1:0] energy_sum;
    logic signed [MAG_W-1:0]    mag_sum;
    logic [PROB_W-1:0]          accept_de4;
    logic [PROB_W-1:0]          accept_de8;

    // outcomes of accepted requests still to come back
    spin_outcome_t pending_updates [$];
    spin_outcome_t oldest_update;
    int            mismatch_count = 0;

    // idling control
    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;
    int                hold_off_req   = 0;
    int                hold_off_left  = 0;
    logic [SITE_W-1:0] last_site      = '0;

    ising_metropolis_spin_update #(
        .LATTICE_SIDE(SIDE)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_site(s_site),
        .s_spin_value(s_spin_value),
        .s_random_fraction(s_random_fraction),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_flipped(m_flipped),
        .m_spin_now(m_spin_now),
        .m_energy(m_energy),
        .m_magnetization(m_magnetization)
    );

    // 20 unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // periodic neighbour: 0 east, 1 west, 2 north, 3 south
    function automatic int neighbour_site(int site, int dir);
        int x;
        int y;
        x = site % SIDE;
        y = site / SIDE;
        case (dir)
            0: return (x + 1) % SIDE + y * SIDE;
            1: return (x + SIDE - 1) % SIDE + y * SIDE;
            2: return x + ((y + SIDE - 1) % SIDE) * SIDE;
            default: return x + ((y + 1) % SIDE) * SIDE;
        endcase
    endfunction

    // metropolis step on the predicted lattice
    function automatic spin_outcome_t predict_spin_update(logic op, logic [SITE_W-1:0] site,
                                                          logic want, logic [RND_W-1:0] rnd);
        spin_outcome_t res;
        int            nsum;
        int            de;
        logic          take;
        res.flipped  = 1'b0;
        res.spin_now = 1'b0;
        if (site < SITE_COUNT) begin
            nsum = 0;
            for (int d = 0; d < 4; d++)
                nsum += lattice_spin[neighbour_site(site, d)] ? 1 : -1;
            de = 2 * (lattice_spin[site] ? 1 : -1) * nsum;
            if (op == OP_WRITE)
                take = (lattice_spin[site] != want);
            else if (de <= 0)
                take = 1'b1;
            else if (de == 4)
                take = (rnd < accept_de4);
            else
                take = (rnd < accept_de8);
            if (take) begin
                lattice_spin[site] = ~lattice_spin[site];
                energy_sum = energy_sum + ENERGY_W'(de);
                mag_sum = lattice_spin[site] ? mag_sum + 2 : mag_sum - 2;
                res.flipped = 1'b1;
            end
            res.spin_now = lattice_spin[site];
        end
        res.energy        = energy_sum;
        res.magnetization = mag_sum;
        return res;
    endfunction

    // receiver: random idling, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with no request pending: flipped %0b spin %0b e %0d m %0d",
                             m_flipped, m_spin_now, m_energy, m_magnetization);
            end else begin
                oldest_update = pending_updates.pop_front();
                if (m_flipped !== oldest_update.flipped ||
                    m_spin_now !== oldest_update.spin_now ||
                    m_energy !== oldest_update.energy ||
                    m_magnetization !== oldest_update.magnetization) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected flipped %0b spin %0b e %0d m %0d, got %0b %0b %0d %0d",
                                 oldest_update.flipped, oldest_update.spin_now,
                                 oldest_update.energy, oldest_update.magnetization,
                                 m_flipped, m_spin_now, m_energy, m_magnetization);
                end
            end
        end
    end

    // send one request, predict its outcome once accepted
    task automatic send_spin_request(input logic op, input logic [SITE_W-1:0] site,
                                     input logic spin, input logic [RND_W-1:0] rnd);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_op              <= op;
        s_site            <= site;
        s_spin_value      <= spin;
        s_random_fraction <= rnd;
        do @(posedge aclk); while (!s_ready);
        pending_updates.push_back(predict_spin_update(op, site, spin, rnd));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_lattice_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // threshold register write, only while idle
    task automatic write_threshold(input logic [CFG_ADDR_W-1:0] idx,
                                   input logic [PROB_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_ACCEPT_DE4)
            accept_de4 = value;
        else
            accept_de8 = value;
    endtask

    // random request, partly clustered around recent sites and thresholds
    task automatic send_random_request();
        logic              op;
        logic [SITE_W-1:0] site;
        logic              spin;
        logic [RND_W-1:0]  rnd;
        int                pick;
        int                x;
        pick = $urandom_range(99);
        if (pick < 35) begin
            site = $urandom_range(SITE_COUNT - 1);
        end else if (pick < 65) begin
            site = neighbour_site(last_site, $urandom_range(3));
        end else if (pick < 80) begin
            x = $urandom_range(SIDE - 1);
            case ($urandom_range(3))
                0: site = x;
                1: site = (SIDE - 1) * SIDE + x;
                2: site = x * SIDE;
                default: site = x * SIDE + SIDE - 1;
            endcase
        end else begin
            site = last_site;
        end
        op   = ($urandom_range(99) < 30) ? OP_WRITE : OP_FLIP;
        spin = $urandom_range(1);
        pick = $urandom_range(99);
        if (pick < 10)
            rnd = accept_de4 + $urandom_range(2) - 1;
        else if (pick < 20)
            rnd = accept_de8 + $urandom_range(2) - 1;
        else if (pick < 25)
            rnd = '0;
        else if (pick < 30)
            rnd = '1;
        else
            rnd = $urandom_range(16'hFFFF);
        last_site = site;
        send_spin_request(op, site, spin, rnd);
    endtask

    // reset thresholds of zero, corner wrap, rewrite of a held spin
    task automatic test_reset_lattice();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_spin_request(OP_FLIP, 12'd0, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd4095, 1'b1, 16'hFFFF);
        send_spin_request(OP_WRITE, 12'd4095, 1'b0, 16'h0000);
        send_spin_request(OP_WRITE, 12'd4095, 1'b0, 16'hFFFF);
        send_spin_request(OP_WRITE, 12'd63, 1'b0, 16'h1234);
        send_spin_request(OP_WRITE, 12'd4032, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd4095, 1'b0, 16'hFFFF);
        wait_lattice_idle();
    endtask

    // acceptance just below and at each threshold, and the always-accept cases
    task automatic test_acceptance_edges();
        write_threshold(CFG_ACCEPT_DE4, 16'h8000);
        write_threshold(CFG_ACCEPT_DE8, 16'hFFFF);
        send_spin_request(OP_WRITE, 12'd2081, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd2080, 1'b0, 16'h8000);
        send_spin_request(OP_FLIP, 12'd2080, 1'b0, 16'h7FFF);
        send_spin_request(OP_FLIP, 12'd2080, 1'b1, 16'hFFFF);
        send_spin_request(OP_FLIP, 12'd2000, 1'b0, 16'hFFFF);
        send_spin_request(OP_FLIP, 12'd2000, 1'b0, 16'hFFFE);
        send_spin_request(OP_FLIP, 12'd2000, 1'b1, 16'hFFFF);
        send_spin_request(OP_WRITE, 12'd2079, 1'b0, 16'h5555);
        send_spin_request(OP_FLIP, 12'd2080, 1'b0, 16'hAAAA);
        send_spin_request(OP_WRITE, 12'd2000, 1'b1, 16'h0001);
        wait_lattice_idle();
    endtask

    // back-to-back requests on the same and adjacent sites
    task automatic test_update_hazards();
        send_spin_request(OP_FLIP, 12'd1000, 1'b0, 16'hFFFE);
        send_spin_request(OP_FLIP, 12'd1001, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd1000, 1'b1, 16'h7FFF);
        send_spin_request(OP_WRITE, 12'd1064, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd1000, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd1000, 1'b0, 16'h0000);
        send_spin_request(OP_FLIP, 12'd936, 1'b1, 16'h7FFF);
        wait_lattice_idle();
    endtask

    // random traffic under one idling mode and one pair of thresholds
    task automatic test_random_sweep(input int count, input int send_pct, input int recv_pct,
                                     input logic [PROB_W-1:0] de4, input logic [PROB_W-1:0] de8);
        write_threshold(CFG_ACCEPT_DE4, de4);
        write_threshold(CFG_ACCEPT_DE8, de8);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_request();
        wait_lattice_idle();
    endtask

    // long receiver hold-off while requests keep coming, so the pipeline fills
    task automatic test_backpressure();
        write_threshold(CFG_ACCEPT_DE4, $urandom_range(16'hFFFF));
        write_threshold(CFG_ACCEPT_DE8, $urandom_range(16'hFFFF));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = HOLD_OFF;
        repeat (40) send_random_request();
        wait_lattice_idle();
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < SITE_COUNT; i++)
            lattice_spin[i] = 1'b1;
        energy_sum = -2 * SITE_COUNT;
        mag_sum    = SITE_COUNT;
        accept_de4 = '0;
        accept_de8 = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // lattice clearing pass holds s_ready low
        do @(posedge aclk); while (!s_ready);

        test_reset_lattice();
        test_acceptance_edges();
        test_update_hazards();
        test_random_sweep(250, 36, 58, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        test_random_sweep(250, 58, 36, 16'hFFFF, 16'h0000);
        test_random_sweep(250, 0, 0, 16'h0000, 16'hFFFF);
        test_backpressure();

        repeat (END_WAIT) @(posedge aclk);
        if (pending_updates.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
